// ----- sv/gsmp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsmp_pkg: shared types for the geometric series matrix power block
// Controller commands, datapath status and state encodings.
// ----------------------------------------------------------------------------
package gsmp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_FINAL,
        ST_DONE
    } ctrl_state_t;

    // Matrix product selector
    typedef enum logic [1:0] {
        MM_ACC_SQ,
        MM_SQ_SQ,
        MM_FINAL,
        MM_REDUCE
    } mm_op_t;

    typedef struct packed {
        logic   load;      // capture inputs, init matrices
        logic   mm_start;  // launch one matrix product
        mm_op_t mm_op;
        logic   shift;     // shift exponent right
    } dp_cmd_t;

    typedef struct packed {
        logic exp_zero;     // exponent is zero
        logic exp_lsb;      // exponent bit 0
        logic exp_one;      // exponent is exactly one
        logic mm_done;      // product finished this cycle
    } dp_status_t;

endpackage
`default_nettype wire

// ----- sv/geometric_series_mod_matrix_power.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// geometric_series_mod_matrix_power: sum of base^i, i < count, mod modulus
// Square-and-multiply of [[base,1],[0,1]] with a bit-serial modular
// multiplier, applied to [1,1].
// ----------------------------------------------------------------------------
//  channel  | handshake            | beat
//  ---------+----------------------+----------------------------------
//  input    | start & !busy        | base_value, term_count, modulus
//  result   | done (one cycle)     | series_sum
//
// One item at a time. The base is first reduced mod modulus, then each
// matrix product is two chained modular multiplies. Reset clears control
// state only, not the data registers. The receiver cannot stall: done is
// high for exactly one cycle per item, busy drops the cycle after.
// ----------------------------------------------------------------------------
module geometric_series_mod_matrix_power
    import gsmp_pkg::*;
#(
    parameter int COUNT_BITS = 40,
    parameter int MOD_BITS   = 30
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic [MOD_BITS-1:0]   base_value,
    input  wire logic [COUNT_BITS-1:0] term_count,
    input  wire logic [MOD_BITS-1:0]   modulus,
    output      logic                  done,
    output      logic [MOD_BITS-1:0]   series_sum
);
    dp_cmd_t    cmd;
    dp_status_t status;
    logic [MOD_BITS-1:0]   sum_raw;
    logic                  zero_reg;

    gsmp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .status(status),
        .cmd(cmd), .busy(busy), .done(done)
    );

    gsmp_datapath #(.COUNT_BITS(COUNT_BITS), .MOD_BITS(MOD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .base_value(base_value),
        .term_count(term_count), .modulus(modulus), .status(status),
        .series_sum(sum_raw)
    );

    // Zero modulus or zero count: empty result
    always_ff @(posedge clk) begin
        if (cmd.load) zero_reg <= (modulus == '0) || (term_count == '0);
    end

    assign series_sum = zero_reg ? '0 : sum_raw;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy) else $error("load while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire

// ----- sv/gsmp_mulmod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsmp_mulmod: sequential modular multiplier
// Computes (a*b) mod m by MSB-first shift-add with two conditional subtracts
// per step, one bit of b a cycle. a is below m; b may be any value.
// ----------------------------------------------------------------------------
module gsmp_mulmod #(
    parameter int MOD_BITS = 30
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [MOD_BITS-1:0] a,
    input  wire logic [MOD_BITS-1:0] b,
    input  wire logic [MOD_BITS-1:0] m,
    output      logic                done,
    output      logic [MOD_BITS-1:0] p
);
    localparam int CW = $clog2(MOD_BITS + 1);

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] a_reg, a_next;
    logic [MOD_BITS-1:0] b_reg, b_next;
    logic [MOD_BITS-1:0] m_reg, m_next;
    logic [MOD_BITS:0]   dbl, dbl_r, add, add_r;

    always_comb begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        add   = dbl_r + (b_reg[MOD_BITS-1] ? {1'b0, a_reg} : '0);
        add_r = (add >= {1'b0, m_reg}) ? add - {1'b0, m_reg} : add;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        // last step; a new start may overlap this cycle
        done      = busy_reg && (cnt_reg == CW'(1));
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(MOD_BITS);
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            m_next    = m;
        end else if (busy_reg) begin
            acc_next = add_r[MOD_BITS-1:0];
            b_next   = {b_reg[MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    assign p = add_r[MOD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end
endmodule
`default_nettype wire

// ----- sv/gsmp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsmp_datapath: matrix registers and product sequencer
// Holds acc and sq as upper rows only (lower rows stay [0,1]), so a 2x2
// product reduces to two modular multiplies and adds.
// ----------------------------------------------------------------------------
module gsmp_datapath
    import gsmp_pkg::*;
#(
    parameter int COUNT_BITS = 40,
    parameter int MOD_BITS   = 30
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    input  wire logic [MOD_BITS-1:0]   base_value,
    input  wire logic [COUNT_BITS-1:0] term_count,
    input  wire logic [MOD_BITS-1:0]   modulus,
    output      dp_status_t            status,
    output      logic [MOD_BITS-1:0]   series_sum
);
    // Upper-triangular [[x,y],[0,1]]: product with [[u,v],[0,1]] is
    // [[x*u, x*v + y],[0,1]]. Final: x + y.
    logic [MOD_BITS-1:0]   m_reg, m_next, ax_reg, ay_reg, sx_reg, sy_reg;
    logic [MOD_BITS-1:0]   ax_next, ay_next, sx_next, sy_next;
    logic [COUNT_BITS-1:0] e_reg, e_next;
    logic [MOD_BITS-1:0]   one_m;
    logic [MOD_BITS:0]     sum_w, sum_r;
    logic                  mul_start, mul_done;
    logic [MOD_BITS-1:0]   mul_a, mul_b, mul_p;
    logic                  phase_reg, phase_next;
    logic [MOD_BITS-1:0]   tx_reg, tx_next;
    mm_op_t                op_reg, op_next;
    logic                  done_c;

    gsmp_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .m(m_next), .done(mul_done), .p(mul_p)
    );

    always_comb begin
        one_m  = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
        m_next = cmd.load ? modulus : m_reg;
        ax_next = ax_reg; ay_next = ay_reg; sx_next = sx_reg; sy_next = sy_reg;
        e_next = e_reg; phase_next = phase_reg; tx_next = tx_reg; op_next = op_reg;
        mul_start = 1'b0;
        done_c    = 1'b0;
        // left operand x, right operand u (phase 0) or v (phase 1)
        mul_a = (op_reg == MM_ACC_SQ) ? ax_reg : sx_reg;
        mul_b = phase_reg ? sy_reg : sx_reg;
        if (cmd.mm_start && cmd.mm_op == MM_FINAL)
            sum_w = {1'b0, ax_reg} + {1'b0, ay_reg};
        else
            sum_w = {1'b0, mul_p} + {1'b0, (op_reg == MM_ACC_SQ) ? ay_reg : sy_reg};
        sum_r = (sum_w >= {1'b0, m_reg}) ? sum_w - {1'b0, m_reg} : sum_w;
        // multiply completion; depends on registered state only
        if (mul_done) begin
            if (op_reg == MM_REDUCE) begin
                sx_next = mul_p;
                done_c  = 1'b1;
            end else if (!phase_reg) begin
                tx_next    = mul_p;
                phase_next = 1'b1;
                mul_start  = 1'b1;
                mul_b      = sy_reg;
            end else begin
                done_c = 1'b1;
                if (op_reg == MM_ACC_SQ) begin
                    ax_next = tx_reg; ay_next = sum_r[MOD_BITS-1:0];
                end else begin
                    sx_next = tx_reg; sy_next = sum_r[MOD_BITS-1:0];
                end
            end
        end
        if (cmd.load) begin
            ax_next = one_m; ay_next = '0;
            sx_next = '0;    sy_next = one_m;
            e_next  = term_count - COUNT_BITS'(1);
        end
        if (cmd.shift) e_next = e_reg >> 1;
        if (cmd.mm_start) begin
            op_next = cmd.mm_op;
            phase_next = 1'b0;
            unique case (cmd.mm_op)
                MM_FINAL: begin
                    ax_next = sum_r[MOD_BITS-1:0];
                end
                MM_REDUCE: begin
                    // base mod m as 1*base, bit by bit
                    mul_start = 1'b1;
                    mul_a     = one_m;
                    mul_b     = base_value;
                end
                MM_ACC_SQ, MM_SQ_SQ: begin
                    mul_start = 1'b1;
                    mul_a = (cmd.mm_op == MM_ACC_SQ) ? ax_reg : sx_reg;
                    mul_b = sx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= 1'b0;
            op_reg    <= MM_FINAL;
        end else begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk) begin
        m_reg  <= m_next;
        ax_reg <= ax_next; ay_reg <= ay_next;
        sx_reg <= sx_next; sy_reg <= sy_next;
        e_reg  <= e_next;  tx_reg <= tx_next;
    end

    assign status.exp_zero = (e_reg == '0);
    assign status.exp_lsb  = e_reg[0];
    assign status.exp_one  = (e_reg == COUNT_BITS'(1));
    assign status.mm_done  = done_c;
    assign series_sum      = ax_reg;
endmodule
`default_nettype wire

// ----- sv/gsmp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsmp_ctrl: square-and-multiply sequencer
// Reduces the base, walks exponent bits (acc*sq, sq*sq), then final sum.
// ----------------------------------------------------------------------------
module gsmp_ctrl
    import gsmp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output      dp_cmd_t    cmd,
    output      logic       busy,
    output      logic       done
);
    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '{load: 1'b0, mm_start: 1'b0, mm_op: MM_FINAL, shift: 1'b0};
        done = 1'b0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.load     = 1'b1;
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_REDUCE;
                    state_next   = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (status.mm_done) state_next = ST_STEP;
            end
            ST_STEP: begin
                priority if (status.exp_zero) begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_FINAL;
                    state_next   = ST_FINAL;
                end else if (status.exp_lsb) begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_ACC_SQ;
                    state_next   = ST_MUL_ACC;
                end else begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_SQ_SQ;
                    cmd.shift    = 1'b1;
                    state_next   = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC: begin
                if (status.mm_done) begin
                    if (status.exp_one) begin
                        cmd.shift  = 1'b1;
                        state_next = ST_STEP;
                    end else begin
                        cmd.mm_start = 1'b1;
                        cmd.mm_op    = MM_SQ_SQ;
                        cmd.shift    = 1'b1;
                        state_next   = ST_MUL_SQ;
                    end
                end
            end
            ST_MUL_SQ: begin
                if (status.mm_done) state_next = ST_STEP;
            end
            ST_FINAL: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- sim/tb_geometric_series_mod_matrix_power.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_geometric_series_mod_matrix_power: self-checking bench for the series block
// Directed corner beats, then random beats, each after a random sender gap. A local
// square-and-multiply model predicts each sum; results are checked in order.
// ----------------------------------------------------------------------------
module tb_geometric_series_mod_matrix_power;

    localparam int COUNT_BITS = 40;
    localparam int MOD_BITS   = 30;
    localparam int N_RANDOM   = 82;
    // Budget for 100 beats and their sender gaps, taken 6x over
    localparam longint CYCLE_LIMIT = 64'd3000000;

    typedef struct {
        logic [MOD_BITS-1:0]   base;
        logic [COUNT_BITS-1:0] count;
        logic [MOD_BITS-1:0]   modv;
        int                    gap;
    } series_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [MOD_BITS-1:0]   base_value;
    logic [COUNT_BITS-1:0] term_count;
    logic [MOD_BITS-1:0]   modulus;
    logic                  done;
    logic [MOD_BITS-1:0]   series_sum;

    series_beat_t          pending_beats[$];
    logic [MOD_BITS-1:0]   expected_sums[$];
    int                    error_count;
    int                    sums_checked;
    longint                cycle_count;
    bit                    stimulus_loaded;
    int                    idle_left;
    bit                    beat_taken;

    geometric_series_mod_matrix_power #(
        .COUNT_BITS(COUNT_BITS),
        .MOD_BITS  (MOD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .base_value(base_value),
        .term_count(term_count),
        .modulus   (modulus),
        .done      (done),
        .series_sum(series_sum)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // 2x2 product mod m; entries stay below 2^31 so 64-bit products are safe
    function automatic void mat_mul(input longint unsigned a[4], input longint unsigned b[4],
                                    input longint unsigned m,
                                    output longint unsigned r[4]);
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                r[2*i+j] = ((a[2*i] * b[j]) % m + (a[2*i+1] * b[2+j]) % m) % m;
            end
        end
    endfunction

    // Sum of base^i for i < count, mod m, via [[b,1],[0,1]]^(count-1)
    function automatic logic [MOD_BITS-1:0] series_mod(input logic [MOD_BITS-1:0] b,
                                                       input logic [COUNT_BITS-1:0] count,
                                                       input logic [MOD_BITS-1:0] mv);
        longint unsigned m;
        longint unsigned acc[4];
        longint unsigned sq[4];
        longint unsigned tmp[4];
        logic [COUNT_BITS-1:0] e;
        m = mv;
        if (m == 0 || count == 0)
            return '0;
        acc = '{1 % m, 0, 0, 1 % m};
        sq  = '{b % m, 1 % m, 0, 1 % m};
        e = count - 1'b1;
        while (e != 0)
        begin
            if (e[0])
            begin
                mat_mul(acc, sq, m, tmp);
                acc = tmp;
            end
            e = e >> 1;
            if (e != 0)
            begin
                mat_mul(sq, sq, m, tmp);
                sq = tmp;
            end
        end
        return MOD_BITS'((acc[0] + acc[1]) % m);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    task automatic queue_beat(input logic [MOD_BITS-1:0] b, input logic [COUNT_BITS-1:0] c,
                              input logic [MOD_BITS-1:0] m);
        series_beat_t beat;
        beat.base  = b;
        beat.count = c;
        beat.modv  = m;
        beat.gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        pending_beats.push_back(beat);
    endtask

    // Stimulus: corners first, then mostly small counts with a few full-width ones
    initial
    begin
        logic [COUNT_BITS-1:0] c;
        logic [MOD_BITS-1:0]   m;
        queue_beat(30'd5, 40'd1, 30'd7);                 // single term
        queue_beat(30'd5, 40'd1, 30'd1);                 // single term, unit modulus
        queue_beat(30'd123, 40'd77, 30'd1);              // unit modulus
        queue_beat(30'd9, 40'd0, 30'd13);                // empty series
        queue_beat(30'd9, 40'd10, 30'd0);                // zero modulus
        queue_beat(30'd0, 40'd0, 30'd0);
        queue_beat(30'd0, 40'd5, 30'd1000);              // zero base
        queue_beat(30'd1, 40'd1000, 30'd997);            // unit base
        queue_beat(30'd2, 40'd10, 30'd1000000);
        queue_beat('1, '1, '1);                          // all extremes
        queue_beat('1, '1, 30'd2);
        queue_beat('1, 40'd2, '1);
        queue_beat(30'd3, '1, '1);
        queue_beat('1, 40'h80_0000_0000, 30'h2000_0000);
        queue_beat(30'h2aaa_aaaa, 40'h55_5555_5555, 30'h1555_5555);
        queue_beat(30'h1555_5555, 40'haa_aaaa_aaaa, 30'h2aaa_aaab);
        queue_beat(30'd7, 40'd2, 30'd3);
        queue_beat(30'd1000, 40'd3, 30'd1001);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            c = COUNT_BITS'({$urandom, $urandom});
            case ($urandom_range(0, 9))
                0:       c = c;                                  // full width
                1:       c = c & 40'hff_ffff;
                2:       c = COUNT_BITS'($urandom_range(0, 3));
                default: c = c & 40'hffff;
            endcase
            m = MOD_BITS'($urandom);
            case ($urandom_range(0, 7))
                0:       m = MOD_BITS'($urandom_range(0, 3));
                1:       m = m & 30'hffff;
                default: m = m;
            endcase
            queue_beat(MOD_BITS'($urandom), c, m);
        end
        stimulus_loaded = 1'b1;
    end

    // Driver: inputs change on the falling edge; a beat is taken at a rising
    // edge with start high and busy low
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        base_value = '0;
        term_count = '0;
        modulus = '0;
        error_count = 0;
        sums_checked = 0;
        cycle_count = 0;
        idle_left = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Accept detection and prediction at the rising edge
    always @(posedge clk)
    begin
        beat_taken <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            expected_sums.push_back(series_mod(base_value, term_count, modulus));
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (beat_taken)
            begin
                start <= 1'b0;
            end
            else if (!start && pending_beats.size() > 0)
            begin
                if (idle_left < pending_beats[0].gap)
                    idle_left <= idle_left + 1;
                else
                begin
                    base_value <= pending_beats[0].base;
                    term_count <= pending_beats[0].count;
                    modulus    <= pending_beats[0].modv;
                    start      <= 1'b1;
                    idle_left  <= 0;
                    void'(pending_beats.pop_front());
                end
            end
        end
    end

    // Monitor: sample on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_sums.size() == 0)
                report_mismatch($sformatf("unexpected sum %0d", series_sum));
            else
            begin
                logic [MOD_BITS-1:0] want;
                want = expected_sums.pop_front();
                if (series_sum !== want)
                    report_mismatch($sformatf("series_sum %0d, expected %0d",
                                              series_sum, want));
                sums_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("geometric_series_mod_matrix_power test failed");
            $finish;
        end
    end

    // End of run: all beats taken, all sums back, then a short drain
    initial
    begin
        wait (stimulus_loaded && rst_n);
        wait (pending_beats.size() == 0 && !start);
        wait (expected_sums.size() == 0);
        repeat (6000) @(posedge clk);
        $display("Checked %0d series sums, corner cases and random beats with sender gaps.",
                 sums_checked);
        if (error_count == 0 && expected_sums.size() == 0)
            $display("geometric_series_mod_matrix_power test passed");
        else
            $display("geometric_series_mod_matrix_power test failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/gsmp_pkg.sv
sv/gsmp_mulmod.sv
sv/gsmp_datapath.sv
sv/gsmp_ctrl.sv
sv/geometric_series_mod_matrix_power.sv
sim/tb_geometric_series_mod_matrix_power.sv
